### hdl/iole_pkg.sv
`default_nettype none
package iole_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int POS_W        = 8;
  localparam int TOTAL_W      = 9;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  localparam logic [KIND_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [KIND_W-1:0] OP_REMOVE     = 3'd5;
  localparam logic [KIND_W-1:0] OP_FIND       = 3'd6;
  localparam logic [KIND_W-1:0] OP_QUERY      = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     ok;
    logic [TOTAL_W-1:0]       found_index;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [TOTAL_W-1:0]       entry_total;
    logic                     is_empty;
  } result_t;

endpackage
`default_nettype wire

### hdl/iole_ram.sv
`default_nettype none
module iole_ram #(
  parameter int DEPTH = iole_pkg::CAPACITY_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [AW-1:0]                    wr_addr,
  input  wire logic signed [iole_pkg::DATA_W-1:0] wr_data,
  input  wire logic                             rd_en,
  input  wire logic [AW-1:0]                    rd_addr,
  output logic signed [iole_pkg::DATA_W-1:0]    rd_data
);

  logic signed [iole_pkg::DATA_W-1:0] mem [DEPTH];

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hdl/indexed_ordered_list_engine_top.sv
`default_nettype none
// Ordered list engine: holds up to CAPACITY signed 32-bit entries in a
// single-port-write, single-port-read memory and runs one command at a time.
// Pulse start while busy is low to hand in a command transaction; busy rises
// on the next cycle and stays high until the result is out. The result
// appears on result for exactly one cycle with done high, and the receiver
// cannot stall it, so capture it then; a new command may be started in that
// same cycle. The index sequencer walks the memory through its one read
// port, reading and then writing back each entry that it shifts; find
// reads and compares each entry in turn. Query and rejected commands only
// read the front and back entries. No clearing pass is needed after reset:
// no entry at or above the entry count ever reaches result.
module indexed_ordered_list_engine_top #(
  parameter int CAPACITY = iole_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire iole_pkg::cmd_t    cmd,
  output logic                   busy,
  output logic                   done,
  output iole_pkg::result_t      result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // common width for comparing the 8-bit position against the count
  localparam int MW = (CW > iole_pkg::POS_W) ? CW : iole_pkg::POS_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_FRONT_RD,
    ST_BACK_RD,
    ST_FINISH
  } state_t;

  state_t                             state;
  iole_pkg::cmd_t                     op;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      idx;
  logic [CW-1:0]                      at;
  logic [CW-1:0]                      found;
  logic                               ok;
  logic signed [iole_pkg::DATA_W-1:0] front;

  // memory port
  logic                               mem_wr_en;
  logic [AW-1:0]                      mem_wr_addr;
  logic signed [iole_pkg::DATA_W-1:0] mem_wr_data;
  logic                               mem_rd_en;
  logic [AW-1:0]                      mem_rd_addr;
  logic signed [iole_pkg::DATA_W-1:0] mem_rd_data;

  logic [CW-1:0] idx_plus;
  logic [CW-1:0] last_idx;
  logic [MW-1:0] pos_ext;
  logic [MW-1:0] count_ext;

  assign idx_plus  = idx + 1'b1;
  assign last_idx  = (count == '0) ? '0 : count - 1'b1;
  assign pos_ext   = MW'(cmd.position);
  assign count_ext = MW'(count);
  assign busy      = (state != ST_IDLE);

  iole_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Memory port steering: every state touches at most one read and one write.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(idx);
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(idx);
    unique case (state)
      ST_UP_RD: begin
        if (idx > at) begin
          // fetch the entry below the hole
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(idx - 1'b1);
        end else begin
          // drop the new value into the opened slot
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(at);
          mem_wr_data = op.value;
        end
      end
      ST_UP_WR: begin
        mem_wr_en = 1'b1;
      end
      ST_DN_RD: begin
        if (idx_plus < count) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(idx_plus);
        end
      end
      ST_DN_WR: begin
        mem_wr_en = 1'b1;
      end
      ST_FIND_RD: begin
        mem_rd_en = (idx < count);
      end
      ST_FRONT_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
      end
      ST_BACK_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(last_idx);
      end
      default: begin
      end
    endcase
  end

  // Sequencer: decode the command, walk the index, then read front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op    <= cmd;
            ok    <= 1'b1;
            found <= '0;
            state <= ST_FRONT_RD;
            unique case (cmd.kind)
              iole_pkg::OP_PUSH_FRONT, iole_pkg::OP_PUSH_BACK,
              iole_pkg::OP_INSERT: begin
                if (count >= FULL_COUNT) begin
                  ok <= 1'b0;
                end else begin
                  idx   <= count;
                  state <= ST_UP_RD;
                  if (cmd.kind == iole_pkg::OP_PUSH_FRONT) begin
                    at <= '0;
                  end else if (cmd.kind == iole_pkg::OP_PUSH_BACK) begin
                    at <= count;
                  end else begin
                    // clamp the index to the count so a far insert appends
                    at <= (pos_ext > count_ext) ? count : CW'(pos_ext);
                  end
                end
              end
              iole_pkg::OP_POP_FRONT: begin
                if (count == '0) begin
                  ok <= 1'b0;
                end else begin
                  idx   <= '0;
                  state <= ST_DN_RD;
                end
              end
              iole_pkg::OP_POP_BACK: begin
                if (count == '0) begin
                  ok <= 1'b0;
                end else begin
                  idx   <= last_idx;
                  state <= ST_DN_RD;
                end
              end
              iole_pkg::OP_REMOVE: begin
                if (pos_ext >= count_ext) begin
                  ok <= 1'b0;
                end else begin
                  idx   <= CW'(pos_ext);
                  state <= ST_DN_RD;
                end
              end
              iole_pkg::OP_FIND: begin
                idx   <= '0;
                state <= ST_FIND_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_UP_RD: begin
          if (idx > at) begin
            state <= ST_UP_WR;
          end else begin
            count <= count + 1'b1;
            state <= ST_FRONT_RD;
          end
        end
        ST_UP_WR: begin
          idx   <= idx - 1'b1;
          state <= ST_UP_RD;
        end
        ST_DN_RD: begin
          if (idx_plus < count) begin
            state <= ST_DN_WR;
          end else begin
            count <= count - 1'b1;
            state <= ST_FRONT_RD;
          end
        end
        ST_DN_WR: begin
          idx   <= idx_plus;
          state <= ST_DN_RD;
        end
        ST_FIND_RD: begin
          if (idx < count) begin
            state <= ST_FIND_CMP;
          end else begin
            found <= count;
            state <= ST_FRONT_RD;
          end
        end
        ST_FIND_CMP: begin
          if (mem_rd_data == op.value) begin
            found <= idx;
            state <= ST_FRONT_RD;
          end else begin
            idx   <= idx_plus;
            state <= ST_FIND_RD;
          end
        end
        ST_FRONT_RD: begin
          state <= ST_BACK_RD;
        end
        ST_BACK_RD: begin
          // hold the front entry while the back entry is fetched
          front <= mem_rd_data;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          done               <= 1'b1;
          result.ok          <= ok;
          result.found_index <= iole_pkg::TOTAL_W'(found);
          result.entry_total <= iole_pkg::TOTAL_W'(count);
          result.is_empty    <= (count == '0);
          result.front_value <= (count == '0) ? iole_pkg::EMPTY_VALUE : front;
          result.back_value  <= (count == '0) ? iole_pkg::EMPTY_VALUE : mem_rd_data;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
